FILE: sv/bpf_pkg.sv
// Package for the Bezier path flattener: payload structs, stack entry,
// sequencer states, command codes and De Casteljau helpers.
// No dependencies.
package bpf_pkg;

    localparam int PT_W      = 24;
    localparam int TOL_W     = 23;
    localparam int IDX_W     = 16;
    localparam int T_W       = 7;
    localparam int LVL_W     = 3;
    localparam int MAX_DEPTH = 6;
    localparam int SP_W      = 3;
    localparam int DIST_W    = 26;
    localparam int MUL_W     = 27;
    localparam int PROD_W    = 54;
    localparam int SQ_W      = 52;
    localparam int NJOBS     = 5;
    localparam int JOB_W     = 3;
    localparam int SQ_STEPS  = 26;
    localparam int CNT_W     = 5;

    localparam logic [2:0] K_MOVE  = 3'd0;
    localparam logic [2:0] K_LINE  = 3'd1;
    localparam logic [2:0] K_QUAD  = 3'd2;
    localparam logic [2:0] K_CUBIC = 3'd3;
    localparam logic [2:0] K_CLOSE = 3'd4;
    localparam logic [2:0] K_ERROR = 3'd4;

    localparam logic [T_W-1:0] T_FULL = 7'd64;
    localparam logic [TOL_W-1:0] TOL_RESET = 23'd256;

    typedef struct packed {
        logic [2:0]             kind;
        logic signed [PT_W-1:0] pt1_x;
        logic signed [PT_W-1:0] pt1_y;
        logic signed [PT_W-1:0] pt2_x;
        logic signed [PT_W-1:0] pt2_y;
        logic signed [PT_W-1:0] pt3_x;
        logic signed [PT_W-1:0] pt3_y;
    } t_cmd;

    typedef struct packed {
        logic [2:0]             span_kind;
        logic [IDX_W-1:0]       src_index;
        logic signed [PT_W-1:0] q0_x;
        logic signed [PT_W-1:0] q0_y;
        logic signed [PT_W-1:0] q1_x;
        logic signed [PT_W-1:0] q1_y;
        logic signed [PT_W-1:0] q2_x;
        logic signed [PT_W-1:0] q2_y;
        logic signed [PT_W-1:0] q3_x;
        logic signed [PT_W-1:0] q3_y;
        logic [T_W-1:0]         t_end;
        logic                   last;
    } t_span;

    typedef struct packed {
        logic [3:0][PT_W-1:0] px;
        logic [3:0][PT_W-1:0] py;
        logic [LVL_W-1:0]     level;
        logic [T_W-1:0]       t_end;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEST,
        ST_MULA,
        ST_MULB,
        ST_SQLD,
        ST_SQRT,
        ST_CRA,
        ST_CRB,
        ST_CRC,
        ST_TOLM,
        ST_DECIDE,
        ST_EMIT,
        ST_POP
    } t_state;

    // Floor midpoint of two signed coordinates.
    function automatic logic [PT_W-1:0] mid(input logic [PT_W-1:0] a,
                                            input logic [PT_W-1:0] b);
        logic [PT_W:0] s;
        s = {a[PT_W-1], a} + {b[PT_W-1], b};
        return s[PT_W:1];
    endfunction

    // Bisect one axis at t = 1/2: returns {right half, left half}.
    function automatic logic [7:0][PT_W-1:0] split_axis(input logic [3:0][PT_W-1:0] p,
                                                        input logic quad);
        logic [PT_W-1:0] a, b, c, d, e, m;
        logic [7:0][PT_W-1:0] r;
        a = mid(p[0], p[1]);
        if (quad) begin
            b = mid(p[1], p[3]);
            m = mid(a, b);
            r = {p[3], p[3], b, m, m, m, a, p[0]};
        end else begin
            b = mid(p[1], p[2]);
            c = mid(p[2], p[3]);
            d = mid(a, b);
            e = mid(b, c);
            m = mid(d, e);
            r = {p[3], c, e, m, m, d, a, p[0]};
        end
        return r;
    endfunction

endpackage

FILE: sv/bezier_path_flattener_unit.sv
// Top level of the Bezier path flattener: command sequencer, pending-half
// stack memory, shared multiplier and bit-serial square root.
// Depends on bpf_pkg.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------
//  command  | in        | i_valid / o_stall        | i_cmd  (t_cmd)
//  span     | out       | o_valid / i_stall        | o_span (t_span)
//  config   | in        | i_cfg_we (no wait)       | i_cfg_data
//
// A move or an error item is answered from the idle step; a line or close
// passes through the test and emit steps. A quad or cubic runs one
// flatness test per tree node (five square roots of 26 steps on the shared
// root unit plus fifteen passes through the one multiplier) and emits
// one piece per leaf; a fully split curve has 63 nodes and 64 leaves.
// Reset (synchronous, active low) clears the cursor, the command counter,
// the stack pointer and the output slot; the stack memory is not cleared.
// Output stalls hold the sequencer in the emit step; new items are taken
// only between commands with the output slot free or draining.
module bezier_path_flattener_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  bpf_pkg::t_cmd              i_cmd,
    output logic                       o_valid,
    input  logic                       i_stall,
    output bpf_pkg::t_span             o_span,
    input  logic                       i_cfg_we,
    input  logic [bpf_pkg::TOL_W-1:0]  i_cfg_data
);
    import bpf_pkg::*;

    t_state r_state, n_state;

    logic [TOL_W-1:0]     r_tol;
    logic [PT_W-1:0]      r_cur_x, r_cur_y, r_start_x, r_start_y;
    logic                 r_have_cursor;
    logic [IDX_W-1:0]     r_count, r_idx;
    logic [2:0]           r_sk;
    logic [3:0][PT_W-1:0] r_x, r_y;
    logic [LVL_W-1:0]     r_level;
    logic [T_W-1:0]       r_t0, r_t1;
    logic [SP_W-1:0]      r_sp;
    logic [JOB_W-1:0]     r_job;
    logic                 r_cr;
    logic [CNT_W-1:0]     r_cnt;
    logic signed [PROD_W-1:0] r_prod, r_sum;
    logic [SQ_W-1:0]      r_v, r_r;
    logic [DIST_W-1:0]    r_d [NJOBS];
    logic [PROD_W-1:0]    r_c [2];
    t_span                r_out;
    logic                 r_ovalid;

    // Stack of pending right halves.
    t_entry               r_mem [MAX_DEPTH];
    t_entry               r_rd;

    // Control decoded from the state.
    logic out_free, accept, emit_go, push, pop_rd;

    assign out_free = !r_ovalid || !i_stall;
    assign o_valid  = r_ovalid;
    assign o_span   = r_out;

    logic [TOL_W-1:0] tol_eff;
    assign tol_eff = (r_tol == '0) ? TOL_W'(1) : r_tol;

    // Distance job endpoints: chord, three polygon edges, then p0->p2.
    logic [PT_W-1:0] ja_x, ja_y, jb_x, jb_y;
    always_comb begin
        ja_x = r_x[0]; ja_y = r_y[0]; jb_x = r_x[3]; jb_y = r_y[3];
        case (r_job)
            3'd0: begin ja_x = r_x[0]; ja_y = r_y[0]; jb_x = r_x[3]; jb_y = r_y[3]; end
            3'd1: begin ja_x = r_x[0]; ja_y = r_y[0]; jb_x = r_x[1]; jb_y = r_y[1]; end
            3'd2: begin ja_x = r_x[1]; ja_y = r_y[1]; jb_x = r_x[2]; jb_y = r_y[2]; end
            3'd3: begin ja_x = r_x[2]; ja_y = r_y[2]; jb_x = r_x[3]; jb_y = r_y[3]; end
            3'd4: begin ja_x = r_x[0]; ja_y = r_y[0]; jb_x = r_x[2]; jb_y = r_y[2]; end
            default: begin ja_x = r_x[0]; ja_y = r_y[0]; jb_x = r_x[3]; jb_y = r_y[3]; end
        endcase
    end

    logic [PT_W:0] jdx, jdy, ex, ey, wx, wy;
    assign jdx = {jb_x[PT_W-1], jb_x} - {ja_x[PT_W-1], ja_x};
    assign jdy = {jb_y[PT_W-1], jb_y} - {ja_y[PT_W-1], ja_y};
    assign ex  = {r_x[3][PT_W-1], r_x[3]} - {r_x[0][PT_W-1], r_x[0]};
    assign ey  = {r_y[3][PT_W-1], r_y[3]} - {r_y[0][PT_W-1], r_y[0]};
    assign wx  = r_cr ? ({r_x[2][PT_W-1], r_x[2]} - {r_x[0][PT_W-1], r_x[0]})
                      : ({r_x[1][PT_W-1], r_x[1]} - {r_x[0][PT_W-1], r_x[0]});
    assign wy  = r_cr ? ({r_y[2][PT_W-1], r_y[2]} - {r_y[0][PT_W-1], r_y[0]})
                      : ({r_y[1][PT_W-1], r_y[1]} - {r_y[0][PT_W-1], r_y[0]});

    // Shared multiplier operands.
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MULA: begin mul_a = {{2{jdx[PT_W]}}, jdx}; mul_b = {{2{jdx[PT_W]}}, jdx}; end
            ST_MULB: begin mul_a = {{2{jdy[PT_W]}}, jdy}; mul_b = {{2{jdy[PT_W]}}, jdy}; end
            ST_CRA:  begin mul_a = {{2{ex[PT_W]}}, ex}; mul_b = {{2{wy[PT_W]}}, wy}; end
            ST_CRB:  begin mul_a = {{2{ey[PT_W]}}, ey}; mul_b = {{2{wx[PT_W]}}, wx}; end
            ST_TOLM: begin
                mul_a = {4'b0, tol_eff};
                mul_b = {1'b0, r_d[0]};
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // One step of the integer square root.
    logic [SQ_W-1:0] sq_bit, sq_trial, n_v, n_r;
    always_comb begin
        sq_bit   = SQ_W'(1) << {r_cnt, 1'b0};
        sq_trial = r_r + sq_bit;
        if (r_v >= sq_trial) begin
            n_v = r_v - sq_trial;
            n_r = (r_r >> 1) + sq_bit;
        end else begin
            n_v = r_v;
            n_r = r_r >> 1;
        end
    end

    // Cross product magnitude.
    logic signed [PROD_W-1:0] cr_diff;
    logic [PROD_W-1:0]        cr_abs;
    assign cr_diff = r_sum - r_prod;
    assign cr_abs  = cr_diff[PROD_W-1] ? PROD_W'(-cr_diff) : PROD_W'(cr_diff);

    // Flatness decision; r_prod holds tol * chord in the decide step.
    logic              chord_zero, perp_ok, poly_ok, flat;
    logic [DIST_W+2:0] excess;
    assign chord_zero = (ex == '0) && (ey == '0);
    assign excess = {3'b0, r_d[1]} + {3'b0, r_d[2]} + {3'b0, r_d[3]} - {3'b0, r_d[0]};
    assign poly_ok = excess[DIST_W+2] || (excess[DIST_W+1:0] <= {5'b0, tol_eff});
    always_comb begin
        if (chord_zero) begin
            perp_ok = (r_d[1] <= {3'b0, tol_eff}) && (r_d[4] <= {3'b0, tol_eff});
        end else begin
            perp_ok = (r_c[0] <= PROD_W'(r_prod)) && (r_c[1] <= PROD_W'(r_prod));
        end
    end
    assign flat = perp_ok && poly_ok;

    logic stop_now;
    assign stop_now = (r_sk == K_LINE) || (r_level >= LVL_W'(MAX_DEPTH))
                   || (r_sp >= SP_W'(MAX_DEPTH));

    // Halves for a split.
    logic [7:0][PT_W-1:0] sx, sy;
    assign sx = split_axis(r_x, r_sk == K_QUAD);
    assign sy = split_axis(r_y, r_sk == K_QUAD);

    logic [T_W:0] t_sum;
    assign t_sum = {1'b0, r_t0} + {1'b0, r_t1};

    logic draw_ok;
    assign draw_ok = r_have_cursor && (i_cmd.kind == K_LINE || i_cmd.kind == K_QUAD
                  || i_cmd.kind == K_CUBIC || i_cmd.kind == K_CLOSE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (accept && i_cmd.kind != K_MOVE && draw_ok) n_state = ST_TEST;
            ST_TEST:   n_state = stop_now ? ST_EMIT : ST_MULA;
            ST_MULA:   n_state = ST_MULB;
            ST_MULB:   n_state = ST_SQLD;
            ST_SQLD:   n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = (r_job == JOB_W'(NJOBS - 1)) ? ST_CRA : ST_MULA;
                end
            end
            ST_CRA:    n_state = ST_CRB;
            ST_CRB:    n_state = ST_CRC;
            ST_CRC:    n_state = r_cr ? ST_TOLM : ST_CRA;
            ST_TOLM:   n_state = ST_DECIDE;
            ST_DECIDE: n_state = flat ? ST_EMIT : ST_TEST;
            ST_EMIT: begin
                if (emit_go) n_state = (r_sp == '0) ? ST_IDLE : ST_POP;
            end
            ST_POP:    n_state = ST_TEST;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_stall = !((r_state == ST_IDLE) && out_free);
        accept  = i_valid && !o_stall;
        emit_go = (r_state == ST_EMIT) && out_free;
        push    = (r_state == ST_DECIDE) && !flat;
        pop_rd  = emit_go && (r_sp != '0);
    end

    // Stack memory: push in the decide step, read in the emit step, so a
    // write and a read never meet in one cycle.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_sp] <= '{px: sx[7:4], py: sy[7:4], level: r_level + 1'b1, t_end: r_t1};
        end
        if (pop_rd) begin
            r_rd <= r_mem[r_sp - 1'b1];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_tol         <= TOL_RESET;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_have_cursor <= 1'b0;
            r_count       <= '0;
            r_sp          <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_tol <= i_cfg_data;
            // Load the output slot on a new item, else drop it once taken.
            if (emit_go || (accept && (i_cmd.kind == K_MOVE || !draw_ok))) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (accept) begin
                r_count <= r_count + 1'b1;
                if (i_cmd.kind == K_MOVE) begin
                    r_cur_x       <= i_cmd.pt1_x;
                    r_cur_y       <= i_cmd.pt1_y;
                    r_start_x     <= i_cmd.pt1_x;
                    r_start_y     <= i_cmd.pt1_y;
                    r_have_cursor <= 1'b1;
                end else if (draw_ok) begin
                    r_sp <= '0;
                    case (i_cmd.kind)
                        K_LINE:  begin r_cur_x <= i_cmd.pt1_x; r_cur_y <= i_cmd.pt1_y; end
                        K_QUAD:  begin r_cur_x <= i_cmd.pt2_x; r_cur_y <= i_cmd.pt2_y; end
                        K_CUBIC: begin r_cur_x <= i_cmd.pt3_x; r_cur_y <= i_cmd.pt3_y; end
                        default: begin r_cur_x <= r_start_x;   r_cur_y <= r_start_y;   end
                    endcase
                end
            end
            if (push) r_sp <= r_sp + 1'b1;
            if (emit_go) begin
                if (r_sp != '0) r_sp <= r_sp - 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_idx <= r_count;
                if (accept) begin
                    if (i_cmd.kind == K_MOVE) begin
                        r_out <= '{span_kind: K_MOVE, src_index: r_count,
                                   q0_x: i_cmd.pt1_x, q0_y: i_cmd.pt1_y,
                                   q1_x: i_cmd.pt1_x, q1_y: i_cmd.pt1_y,
                                   q2_x: i_cmd.pt1_x, q2_y: i_cmd.pt1_y,
                                   q3_x: i_cmd.pt1_x, q3_y: i_cmd.pt1_y,
                                   t_end: '0, last: 1'b1};
                    end else if (!draw_ok) begin
                        r_out <= '{span_kind: K_ERROR, src_index: r_count,
                                   q0_x: '0, q0_y: '0, q1_x: '0, q1_y: '0,
                                   q2_x: '0, q2_y: '0, q3_x: '0, q3_y: '0,
                                   t_end: '0, last: 1'b1};
                    end
                end
                r_x[0]  <= r_cur_x;
                r_y[0]  <= r_cur_y;
                r_level <= '0;
                r_t0    <= '0;
                r_t1    <= T_FULL;
                case (i_cmd.kind)
                    K_QUAD: begin
                        r_sk   <= K_QUAD;
                        r_x[1] <= i_cmd.pt1_x; r_y[1] <= i_cmd.pt1_y;
                        r_x[2] <= i_cmd.pt2_x; r_y[2] <= i_cmd.pt2_y;
                        r_x[3] <= i_cmd.pt2_x; r_y[3] <= i_cmd.pt2_y;
                    end
                    K_CUBIC: begin
                        r_sk   <= K_CUBIC;
                        r_x[1] <= i_cmd.pt1_x; r_y[1] <= i_cmd.pt1_y;
                        r_x[2] <= i_cmd.pt2_x; r_y[2] <= i_cmd.pt2_y;
                        r_x[3] <= i_cmd.pt3_x; r_y[3] <= i_cmd.pt3_y;
                    end
                    K_LINE: begin
                        r_sk   <= K_LINE;
                        r_x[1] <= i_cmd.pt1_x; r_y[1] <= i_cmd.pt1_y;
                        r_x[2] <= i_cmd.pt1_x; r_y[2] <= i_cmd.pt1_y;
                        r_x[3] <= i_cmd.pt1_x; r_y[3] <= i_cmd.pt1_y;
                    end
                    default: begin
                        r_sk   <= K_LINE;
                        r_x[1] <= r_start_x; r_y[1] <= r_start_y;
                        r_x[2] <= r_start_x; r_y[2] <= r_start_y;
                        r_x[3] <= r_start_x; r_y[3] <= r_start_y;
                    end
                endcase
            end
            ST_TEST: begin
                r_job <= '0;
                r_cr  <= 1'b0;
            end
            ST_MULA: r_prod <= mul_p;
            ST_MULB: begin
                r_sum  <= r_prod;
                r_prod <= mul_p;
            end
            ST_SQLD: begin
                r_v   <= SQ_W'(r_sum) + SQ_W'(r_prod);
                r_r   <= '0;
                r_cnt <= CNT_W'(SQ_STEPS - 1);
            end
            ST_SQRT: begin
                r_v   <= n_v;
                r_r   <= n_r;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_d[r_job] <= n_r[DIST_W-1:0];
                    r_job      <= r_job + 1'b1;
                end
            end
            ST_CRA: r_prod <= mul_p;
            ST_CRB: begin
                r_sum  <= r_prod;
                r_prod <= mul_p;
            end
            ST_CRC: begin
                r_c[r_cr] <= cr_abs;
                r_cr      <= 1'b1;
            end
            ST_TOLM: r_prod <= mul_p;
            ST_DECIDE: begin
                if (!flat) begin
                    // Keep the left half, descend one level.
                    r_x     <= sx[3:0];
                    r_y     <= sy[3:0];
                    r_level <= r_level + 1'b1;
                    r_t1    <= t_sum[T_W:1];
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_out <= '{span_kind: r_sk, src_index: r_idx,
                               q0_x: r_x[0], q0_y: r_y[0], q1_x: r_x[1], q1_y: r_y[1],
                               q2_x: r_x[2], q2_y: r_y[2], q3_x: r_x[3], q3_y: r_y[3],
                               t_end: r_t1, last: (r_sp == '0)};
                    r_t0 <= r_t1;
                end
            end
            ST_POP: begin
                // Resume the most recent pending half.
                r_x     <= r_rd.px;
                r_y     <= r_rd.py;
                r_level <= r_rd.level;
                r_t1    <= r_rd.t_end;
            end
            default: r_job <= r_job;
        endcase
    end

endmodule

FILE: test/tb_bezier_path_flattener_unit.sv
// Testbench for bezier_path_flattener_unit: path commands go in, flat curve
// pieces come out and are checked against a built-in flattening predictor.
// Depends on bpf_pkg and the RTL of bezier_path_flattener_unit.
`timescale 1ns / 1ps

module tb_bezier_path_flattener_unit;
    import bpf_pkg::*;

    // Kind codes the block does not define; they must come back as errors.
    localparam logic [2:0] K_UNDEF_LO  = 3'd5;
    localparam logic [2:0] K_UNDEF_MID = 3'd6;
    localparam logic [2:0] K_UNDEF_HI  = 3'd7;
    localparam logic [PT_W-1:0] PT_MAX = 24'h7FFFFF;
    localparam logic [PT_W-1:0] PT_MIN = 24'h800000;
    localparam logic [TOL_W-1:0] TOL_MAX = 23'h7FFFFF;
    localparam int IDLE_LIMIT = 30000;
    localparam int HOLD_CYCLES = 300;

    typedef longint t_coord4 [4];
    typedef struct {
        bit    fixed;
        t_span span;
    } t_typed_exp;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    t_cmd             i_cmd;
    logic             o_valid;
    logic             i_stall;
    t_span            o_span;
    logic             i_cfg_we;
    logic [TOL_W-1:0] i_cfg_data;

    bezier_path_flattener_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_span     (o_span),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: pen position, subpath start, command counter, tolerance.
    longint           pen_x, pen_y, sub_x, sub_y;
    bit               pen_set;
    logic [IDX_W-1:0] seq_num;
    logic [TOL_W-1:0] tol_reg;

    t_span      span_q[$];     // pieces still owed by the block, oldest first
    t_typed_exp typed_q[$];    // per accepted item: a hand-written result or none
    int         fails;
    int         idle_cycles;
    bit         steady;        // no random gaps on either side
    bit         hold_req;      // ask the receiver for one long hold-off

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Flattening predictor
    // ---------------------------------------------------------------
    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint seg_len(input longint ax, ay, bx, by);
        longint dx, dy;
        dx = bx - ax;
        dy = by - ay;
        return longint'(int_root(longint'(dx * dx + dy * dy)));
    endfunction

    // Control point close enough to the chord line (or to p0 for a zero chord).
    function automatic bit near_chord(input longint px, py, input t_coord4 x, y,
                                      input longint chord, tol);
        longint ex, ey, c;
        ex = x[3] - x[0];
        ey = y[3] - y[0];
        if (ex == 0 && ey == 0) return seg_len(x[0], y[0], px, py) <= tol;
        c = ex * (py - y[0]) - ey * (px - x[0]);
        if (c < 0) c = -c;
        return c <= tol * chord;
    endfunction

    function automatic bit piece_flat(input t_coord4 x, y, input logic [2:0] sk,
                                      input longint tol);
        longint chord, poly;
        bit ok;
        if (sk == K_LINE) return 1'b1;
        chord = seg_len(x[0], y[0], x[3], y[3]);
        poly = seg_len(x[0], y[0], x[1], y[1]) + seg_len(x[1], y[1], x[2], y[2]);
        ok = near_chord(x[1], y[1], x, y, chord, tol);
        if (sk == K_CUBIC) begin
            poly += seg_len(x[2], y[2], x[3], y[3]);
            ok = ok && near_chord(x[2], y[2], x, y, chord, tol);
        end
        return ok && (poly - chord) <= tol;
    endfunction

    function automatic longint halfway(input longint a, b);
        return (a + b) >>> 1;
    endfunction

    // Bisect one axis at t = 1/2: left half stays in p, right half goes to r.
    function automatic void bisect(inout t_coord4 p, output t_coord4 r, input bit quad);
        longint a, b, c, d, e, m;
        a = halfway(p[0], p[1]);
        if (quad) begin
            b = halfway(p[1], p[3]);
            m = halfway(a, b);
            r = '{m, b, p[3], p[3]};
            p = '{p[0], a, m, m};
        end else begin
            b = halfway(p[1], p[2]);
            c = halfway(p[2], p[3]);
            d = halfway(a, b);
            e = halfway(b, c);
            m = halfway(d, e);
            r = '{m, e, c, p[3]};
            p = '{p[0], a, d, m};
        end
    endfunction

    function automatic t_span make_span(input logic [2:0] sk, input logic [IDX_W-1:0] idx,
                                        input t_coord4 x, y, input int te, input bit lst);
        t_span s;
        s.span_kind = sk;
        s.src_index = idx;
        s.q0_x = x[0][PT_W-1:0];
        s.q0_y = y[0][PT_W-1:0];
        s.q1_x = x[1][PT_W-1:0];
        s.q1_y = y[1][PT_W-1:0];
        s.q2_x = x[2][PT_W-1:0];
        s.q2_y = y[2][PT_W-1:0];
        s.q3_x = x[3][PT_W-1:0];
        s.q3_y = y[3][PT_W-1:0];
        s.t_end = te[T_W-1:0];
        s.last = lst;
        return s;
    endfunction

    // Advance the predictor by one command and append what it emits to pieces.
    function automatic void flatten_cmd(input t_cmd c, inout t_span pieces[$]);
        t_coord4 x, y, rx, ry;
        t_coord4 stk_x [MAX_DEPTH];
        t_coord4 stk_y [MAX_DEPTH];
        int stk_lvl [MAX_DEPTH];
        int stk_te [MAX_DEPTH];
        int sp, lvl, t0, t1, tm;
        logic [2:0] sk;
        logic [IDX_W-1:0] idx;
        longint tol;
        idx = seq_num;
        seq_num = seq_num + 1'b1;
        tol = (tol_reg == 0) ? 1 : longint'(tol_reg);
        if (c.kind == K_MOVE) begin
            pen_x = longint'(c.pt1_x);
            pen_y = longint'(c.pt1_y);
            sub_x = pen_x;
            sub_y = pen_y;
            pen_set = 1'b1;
            x = '{pen_x, pen_x, pen_x, pen_x};
            y = '{pen_y, pen_y, pen_y, pen_y};
            pieces.push_back(make_span(K_MOVE, idx, x, y, 0, 1'b1));
            return;
        end
        if (c.kind > K_CLOSE || !pen_set) begin
            x = '{0, 0, 0, 0};
            pieces.push_back(make_span(K_ERROR, idx, x, x, 0, 1'b1));
            return;
        end
        x[0] = pen_x;
        y[0] = pen_y;
        if (c.kind == K_LINE || c.kind == K_CLOSE) begin
            x[1] = (c.kind == K_LINE) ? longint'(c.pt1_x) : sub_x;
            y[1] = (c.kind == K_LINE) ? longint'(c.pt1_y) : sub_y;
            x[2] = x[1]; x[3] = x[1];
            y[2] = y[1]; y[3] = y[1];
            sk = K_LINE;
        end else if (c.kind == K_QUAD) begin
            x[1] = longint'(c.pt1_x); y[1] = longint'(c.pt1_y);
            x[2] = longint'(c.pt2_x); y[2] = longint'(c.pt2_y);
            x[3] = x[2];              y[3] = y[2];
            sk = K_QUAD;
        end else begin
            x[1] = longint'(c.pt1_x); y[1] = longint'(c.pt1_y);
            x[2] = longint'(c.pt2_x); y[2] = longint'(c.pt2_y);
            x[3] = longint'(c.pt3_x); y[3] = longint'(c.pt3_y);
            sk = K_CUBIC;
        end
        pen_x = x[3];
        pen_y = y[3];
        sp = 0; lvl = 0; t0 = 0; t1 = 64;
        forever begin
            if (lvl >= MAX_DEPTH || sp >= MAX_DEPTH || piece_flat(x, y, sk, tol)) begin
                pieces.push_back(make_span(sk, idx, x, y, t1, sp == 0));
                t0 = t1;
                if (sp == 0) break;
                sp--;
                x = stk_x[sp];
                y = stk_y[sp];
                lvl = stk_lvl[sp];
                t1 = stk_te[sp];
            end else begin
                tm = (t0 + t1) >> 1;
                bisect(x, rx, sk == K_QUAD);
                bisect(y, ry, sk == K_QUAD);
                stk_x[sp] = rx;
                stk_y[sp] = ry;
                stk_lvl[sp] = lvl + 1;
                stk_te[sp] = t1;
                sp++;
                lvl++;
                t1 = tm;
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Monitors: predict on every accepted command, check every piece
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_span      got[$];
        t_typed_exp te;
        if (i_rst_n && i_valid && !o_stall) begin
            got = {};
            flatten_cmd(i_cmd, got);
            te = typed_q.pop_front();
            // Hand-written rows stand for one single result; use them in place.
            if (te.fixed) got = '{te.span};
            foreach (got[k]) span_q.push_back(got[k]);
        end
    end

    task automatic cmp_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_span e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (span_q.size() == 0) begin
                $display("%0t unexpected piece: expected none actual %h", $time, o_span);
                fails++;
            end else begin
                e = span_q.pop_front();
                cmp_field("span_kind", e.span_kind, o_span.span_kind);
                cmp_field("src_index", e.src_index, o_span.src_index);
                cmp_field("q0_x", e.q0_x, o_span.q0_x);
                cmp_field("q0_y", e.q0_y, o_span.q0_y);
                cmp_field("q1_x", e.q1_x, o_span.q1_x);
                cmp_field("q1_y", e.q1_y, o_span.q1_y);
                cmp_field("q2_x", e.q2_x, o_span.q2_x);
                cmp_field("q2_y", e.q2_y, o_span.q2_y);
                cmp_field("q3_x", e.q3_x, o_span.q3_x);
                cmp_field("q3_y", e.q3_y, o_span.q3_y);
                cmp_field("t_end", e.t_end, o_span.t_end);
                cmp_field("last", e.last, o_span.last);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t timeout: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stall before each piece, plus one long hold-off on request.
    initial begin
        int gap;
        i_stall = 1'b0;
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic t_cmd make_cmd(input logic [2:0] k,
                                      input logic [PT_W-1:0] ax, ay, bx, by, cx, cy);
        t_cmd c;
        c.kind = k;
        c.pt1_x = ax; c.pt1_y = ay;
        c.pt2_x = bx; c.pt2_y = by;
        c.pt3_x = cx; c.pt3_y = cy;
        return c;
    endfunction

    // Move result or error result: every point the same, t_end zero, last set.
    function automatic t_typed_exp single(input logic [2:0] sk, input logic [IDX_W-1:0] idx,
                                          input logic [PT_W-1:0] px, py);
        t_typed_exp t;
        t_coord4 x, y;
        x = '{longint'(signed'(px)), longint'(signed'(px)),
              longint'(signed'(px)), longint'(signed'(px))};
        y = '{longint'(signed'(py)), longint'(signed'(py)),
              longint'(signed'(py)), longint'(signed'(py))};
        t.fixed = 1'b1;
        t.span = make_span(sk, idx, x, y, 0, 1'b1);
        return t;
    endfunction

    task automatic send(input t_cmd c, input t_typed_exp te);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        typed_q.push_back(te);
        i_valid <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Lower valid and wait until every owed piece has come out.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (span_q.size() != 0) @(posedge i_clk);
    endtask

    // Write the tolerance only with the block idle; give it time to settle first.
    task automatic write_tol(input logic [TOL_W-1:0] v);
        drain();
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        tol_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [PT_W-1:0] pick_coord(input int w);
        if ($urandom_range(0, 19) == 0) return PT_W'($urandom);
        return PT_W'(int'($urandom_range(0, 2 * w)) - w);
    endfunction

    function automatic t_cmd random_cmd(input int w);
        int r;
        logic [2:0] k;
        r = $urandom_range(0, 99);
        if (r < 4) k = 3'($urandom_range(K_UNDEF_LO, K_UNDEF_HI));
        else if (r < 14) k = K_MOVE;
        else if (r < 34) k = K_LINE;
        else if (r < 42) k = K_CLOSE;
        else if (r < 70) k = K_QUAD;
        else k = K_CUBIC;
        return make_cmd(k, pick_coord(w), pick_coord(w), pick_coord(w),
                        pick_coord(w), pick_coord(w), pick_coord(w));
    endfunction

    function automatic logic [TOL_W-1:0] rand_tol();
        return TOL_W'($urandom_range(2, 1 << 12));
    endfunction

    initial begin
        t_cmd       rows[$];
        t_typed_exp row_exp[$];
        t_typed_exp none;
        logic [TOL_W-1:0] tol_plan [6];
        int         width_plan [6];

        none.fixed = 1'b0;
        none.span = '0;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        fails = 0;
        idle_cycles = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        pen_x = 0; pen_y = 0; sub_x = 0; sub_y = 0;
        pen_set = 1'b0;
        seq_num = '0;
        tol_reg = TOL_RESET;

        // Directed rows; indexes count from reset, so typed results name them.
        rows.push_back(make_cmd(K_LINE, 24'd256, 24'd512, 0, 0, 0, 0));
        row_exp.push_back(single(K_ERROR, 16'd0, 0, 0));         // draw before any move
        rows.push_back(make_cmd(K_UNDEF_HI, 24'd5, 24'd5, 0, 0, 0, 0));
        row_exp.push_back(single(K_ERROR, 16'd1, 0, 0));
        rows.push_back(make_cmd(K_CLOSE, 0, 0, 0, 0, 0, 0));
        row_exp.push_back(single(K_ERROR, 16'd2, 0, 0));
        rows.push_back(make_cmd(K_MOVE, PT_MAX, PT_MIN, 0, 0, 0, 0));
        row_exp.push_back(single(K_MOVE, 16'd3, PT_MAX, PT_MIN));
        rows.push_back(make_cmd(K_LINE, PT_MIN, PT_MAX, 0, 0, 0, 0));
        row_exp.push_back(none);
        rows.push_back(make_cmd(K_QUAD, PT_MAX, PT_MAX, PT_MIN, PT_MIN, 0, 0));
        row_exp.push_back(none);
        rows.push_back(make_cmd(K_CUBIC, PT_MIN, PT_MAX, PT_MAX, PT_MIN, PT_MAX, PT_MAX));
        row_exp.push_back(none);
        rows.push_back(make_cmd(K_CLOSE, 0, 0, 0, 0, 0, 0));
        row_exp.push_back(none);
        rows.push_back(make_cmd(K_UNDEF_LO, PT_MAX, PT_MAX, 0, 0, 0, 0));
        row_exp.push_back(single(K_ERROR, 16'd8, 0, 0));         // bad kind after a move
        rows.push_back(make_cmd(K_MOVE, 0, 0, 0, 0, 0, 0));
        row_exp.push_back(single(K_MOVE, 16'd9, 0, 0));
        rows.push_back(make_cmd(K_CUBIC, 0, 0, 0, 0, 0, 0));      // zero chord, all points equal
        row_exp.push_back(none);
        rows.push_back(make_cmd(K_QUAD, 24'd5000, -24'sd3000, 0, 0, 0, 0));  // zero chord, bent
        row_exp.push_back(none);
        rows.push_back(make_cmd(K_CUBIC, 24'd900, 24'd100, -24'sd900, 24'd700, 0, 0));
        row_exp.push_back(none);
        rows.push_back(make_cmd(K_UNDEF_MID, 0, 0, 0, 0, 0, 0));
        row_exp.push_back(single(K_ERROR, 16'd13, 0, 0));
        rows.push_back(make_cmd(K_MOVE, -24'sd256, 24'd512, 0, 0, 0, 0));
        row_exp.push_back(single(K_MOVE, 16'd14, -24'sd256, 24'd512));
        rows.push_back(make_cmd(K_LINE, 24'd1024, 24'd1024, 0, 0, 0, 0));
        row_exp.push_back(none);
        rows.push_back(make_cmd(K_QUAD, 24'd3000, 24'd100, 24'd2048, -24'sd512, 0, 0));
        row_exp.push_back(none);
        rows.push_back(make_cmd(K_CUBIC, 24'd100, 24'd4000, 24'd3000, -24'sd4000,
                                24'd200, 24'd300));
        row_exp.push_back(none);
        rows.push_back(make_cmd(K_CUBIC, PT_MIN, PT_MIN, PT_MIN, PT_MAX, PT_MIN, PT_MIN));
        row_exp.push_back(none);
        rows.push_back(make_cmd(K_CLOSE, 0, 0, 0, 0, 0, 0));
        row_exp.push_back(none);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) send(rows[r], row_exp[r]);

        // Tolerance settings for the random phases, extremes included; small
        // tolerances get small shapes so the subdivision trees stay cheap.
        tol_plan = '{23'd1, 23'd0, TOL_MAX, 23'd64, rand_tol(), TOL_RESET};
        width_plan = '{64, 64, 1 << 20, 2000, 4000, 8000};
        for (int ph = 0; ph < 6; ph++) begin
            write_tol(tol_plan[ph]);
            steady = (ph == 3);
            send(make_cmd(K_MOVE, pick_coord(width_plan[ph]), pick_coord(width_plan[ph]),
                          0, 0, 0, 0), none);
            if (ph == 2) begin
                // Block the output for a long stretch while lines keep coming.
                hold_req = 1'b1;
                for (int n = 0; n < 20; n++)
                    send(make_cmd(K_LINE, pick_coord(5000), pick_coord(5000),
                                  0, 0, 0, 0), none);
            end
            for (int n = 0; n < 58; n++) send(random_cmd(width_plan[ph]), none);
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/bpf_pkg.sv
sv/bezier_path_flattener_unit.sv
test/tb_bezier_path_flattener_unit.sv
